### hw/rtl/ocd_pkg.sv
// Shared types and constants for the oscillator divider / RFREQ calculator.
// Used by ocd_arith and oscillator_divider_rfreq_calc_unit.
package ocd_pkg;

  localparam int unsigned ACC_W = 72;
  localparam int unsigned DEN_W = 40;
  localparam int unsigned CNT_W = 7;

  typedef enum logic {
    OCD_MUL,
    OCD_DIV
  } ocd_op_t;

  typedef struct packed {
    logic             start;
    ocd_op_t          op;
    logic [CNT_W-1:0] nbits;
  } ocd_req_t;

  localparam logic [1:0] CFG_XTAL    = 2'd0;
  localparam logic [1:0] CFG_PPM     = 2'd1;
  localparam logic [1:0] CFG_DCO_MIN = 2'd2;
  localparam logic [1:0] CFG_DCO_MAX = 2'd3;

  localparam logic [31:0] XTAL_RST    = 32'd1917384131;
  localparam logic [15:0] PPM_RST     = 16'd3500;
  localparam logic [12:0] DCO_MIN_RST = 13'd4850;
  localparam logic [12:0] DCO_MAX_RST = 13'd5670;

  localparam logic [1:0] ST_SMOOTH  = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [19:0] PPM_SCALE = 20'd1000000;
  localparam logic [34:0] HALF_MHZ  = 35'd8388608;

  function automatic logic [3:0] hs_of(input logic [2:0] idx);
    logic [3:0] hs;
    case (idx)
      3'd0:    hs = 4'd11;
      3'd1:    hs = 4'd9;
      3'd2:    hs = 4'd7;
      3'd3:    hs = 4'd6;
      3'd4:    hs = 4'd5;
      default: hs = 4'd4;
    endcase
    return hs;
  endfunction

  // ceil(2^16 / HS); exact floor for dividends below 2048
  function automatic logic [14:0] hs_recip_of(input logic [2:0] idx);
    logic [14:0] m;
    case (idx)
      3'd0:    m = 15'd5958;
      3'd1:    m = 15'd7282;
      3'd2:    m = 15'd9363;
      3'd3:    m = 15'd10923;
      3'd4:    m = 15'd13108;
      default: m = 15'd16384;
    endcase
    return m;
  endfunction

endpackage

### hw/rtl/oscillator_divider_rfreq_calc_unit.sv
// Top level of the oscillator divider and RFREQ calculator.
// Depends on ocd_pkg and ocd_arith.
//
// Input channel in_*: one target frequency (Q11.24 MHz) per item.
// Result channel out_*: one status and 48-bit register image per item.
// Config channel cfg_*: ready only while the sequencer is idle; a pending
// write holds off the input channel for that cycle.
// in_ready is high only while the sequencer is idle. The HS/N1 search uses
// reciprocal multiplies, one HS per cycle; every other step runs through one
// shared bit-serial multiply/divide unit: the N0 divide, f*N, the RFREQ
// divide, the frequency rebuild multiply and divide and two ppm multiplies.
// No new item is accepted until the last one is handed to the output
// register. A zero target or a zero crystal, a missing divider or too high
// a DCO ends the item early with invalid status.
// The result sits in an output register; a stalled receiver holds the item
// there and the block finishes the next item only once it is taken.
// Synchronous reset restores the register defaults, clears the reference
// and image state and forces the next valid target to a full update.
module oscillator_divider_rfreq_calc_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [34:0] in_target_freq,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [47:0] out_register_image,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import ocd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_N0, S_HS, S_CHK, S_DCO, S_RF, S_PR, S_FQ, S_M1, S_M2, S_FIN
  } state_t;

  state_t           state_r;
  logic [31:0]      xtal_r;
  logic [15:0]      ppm_r;
  logic [12:0]      dmin_r, dmax_r;
  logic [47:0]      cur_img_r;
  logic [37:0]      ref_rf_r;
  logic [34:0]      ref_f_r;
  logic             ref_ok_r;

  logic [34:0]      f_r;
  logic [36:0]      n0_r;
  logic [2:0]       idx_r;
  logic             found_r;
  logic [10:0]      best_n_r;
  logic [3:0]       best_hs_r;
  logic [7:0]       best_n1_r;
  logic [37:0]      rf_r;
  logic [34:0]      fq_r;
  logic             dfbig_r;
  logic [57:0]      lhs_r;
  logic [1:0]       st_r;
  logic             full_r;

  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [47:0]      out_img_r;

  ocd_req_t         req_r;
  logic [ACC_W-1:0] opx_r;
  logic [DEN_W-1:0] opd_r;
  logic             a_done;
  logic [ACC_W-1:0] a_acc, a_quo;

  logic [3:0]       hs;
  logic [14:0]      hrec;
  logic [25:0]      hq;
  logic [7:0]       n1_raw, n1;
  logic [11:0]      prod;
  logic [45:0]      dco;
  logic [34:0]      fq;
  logic [37:0]      d_rf;
  logic [34:0]      d_f;
  logic [47:0]      img;

  ocd_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_r),
    .opx   (opx_r),
    .opd   (opd_r),
    .done  (a_done),
    .acc   (a_acc),
    .quo   (a_quo)
  );

  always_comb begin
    hs     = hs_of(idx_r);
    hrec   = hs_recip_of(idx_r);
    hq     = {15'd0, n0_r[10:0]} * {11'd0, hrec};
    n1_raw = {1'b0, hq[22:16]} + 8'd1;
    n1     = (n1_raw != 8'd1 && n1_raw[0]) ? n1_raw + 8'd1 : n1_raw;
    prod   = {8'd0, hs} * {4'd0, n1};
    dco    = a_acc[45:0];
    fq     = (|a_quo[41:35]) ? '1 : a_quo[34:0];
    d_rf   = (rf_r >= ref_rf_r) ? rf_r - ref_rf_r : ref_rf_r - rf_r;
    d_f    = (fq >= ref_f_r) ? fq - ref_f_r : ref_f_r - fq;
    img    = {best_hs_r[2:0] - 3'd4, best_n1_r[6:0] - 7'd1, rf_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      xtal_r      <= XTAL_RST;
      ppm_r       <= PPM_RST;
      dmin_r      <= DCO_MIN_RST;
      dmax_r      <= DCO_MAX_RST;
      cur_img_r   <= '0;
      ref_rf_r    <= '0;
      ref_f_r     <= '0;
      ref_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
      req_r       <= '{start: 1'b0, op: OCD_MUL, nbits: '0};
    end else begin
      if (req_r.start) req_r.start <= 1'b0;
      if (out_valid_r && out_ready && state_r != S_FIN) out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_XTAL:    xtal_r <= cfg_data;
          CFG_PPM:     ppm_r  <= cfg_data[15:0];
          CFG_DCO_MIN: dmin_r <= cfg_data[12:0];
          CFG_DCO_MAX: dmax_r <= cfg_data[12:0];
          default:     ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            f_r <= in_target_freq;
            if (in_target_freq == '0 || xtal_r == '0) begin
              st_r    <= ST_INVALID;
              state_r <= S_FIN;
            end else begin
              req_r   <= '{start: 1'b1, op: OCD_DIV, nbits: CNT_W'(37)};
              opx_r   <= {dmin_r, 24'd0, 35'd0};
              opd_r   <= {5'd0, in_target_freq};
              state_r <= S_N0;
            end
          end
        end
        S_N0: begin
          if (a_done) begin
            n0_r    <= a_quo[36:0];
            idx_r   <= '0;
            found_r <= 1'b0;
            state_r <= S_HS;
          end
        end
        S_HS: begin
          if (idx_r == 3'd6) begin
            state_r <= S_CHK;
          end else begin
            if (n0_r < {26'd0, hs, 7'd0} && (!found_r || prod[10:0] < best_n_r)) begin
              found_r   <= 1'b1;
              best_n_r  <= prod[10:0];
              best_hs_r <= hs;
              best_n1_r <= n1;
            end
            idx_r <= idx_r + 3'd1;
          end
        end
        S_CHK: begin
          if (!found_r) begin
            st_r    <= ST_INVALID;
            state_r <= S_FIN;
          end else begin
            req_r   <= '{start: 1'b1, op: OCD_MUL, nbits: CNT_W'(11)};
            opx_r   <= {best_n_r, 61'd0};
            opd_r   <= {5'd0, f_r};
            state_r <= S_DCO;
          end
        end
        S_DCO: begin
          if (a_done) begin
            if (dco > {9'd0, dmax_r, 24'd0}) begin
              st_r    <= ST_INVALID;
              state_r <= S_FIN;
            end else begin
              req_r   <= '{start: 1'b1, op: OCD_DIV, nbits: CNT_W'(65)};
              opx_r   <= {dco[36:0], 35'd0};
              opd_r   <= {8'd0, xtal_r};
              state_r <= S_RF;
            end
          end
        end
        S_RF: begin
          if (a_done) begin
            rf_r    <= a_quo[37:0];
            req_r   <= '{start: 1'b1, op: OCD_MUL, nbits: CNT_W'(32)};
            opx_r   <= {xtal_r, 40'd0};
            opd_r   <= {2'd0, a_quo[37:0]};
            state_r <= S_PR;
          end
        end
        S_PR: begin
          if (a_done) begin
            req_r   <= '{start: 1'b1, op: OCD_DIV, nbits: CNT_W'(42)};
            opx_r   <= {a_acc[69:28], 30'd0};
            opd_r   <= {29'd0, best_n_r};
            state_r <= S_FQ;
          end
        end
        S_FQ: begin
          if (a_done) begin
            fq_r    <= fq;
            dfbig_r <= (d_f > HALF_MHZ);
            req_r   <= '{start: 1'b1, op: OCD_MUL, nbits: CNT_W'(20)};
            opx_r   <= {PPM_SCALE, 52'd0};
            opd_r   <= {2'd0, d_rf};
            state_r <= S_M1;
          end
        end
        S_M1: begin
          if (a_done) begin
            lhs_r   <= a_acc[57:0];
            req_r   <= '{start: 1'b1, op: OCD_MUL, nbits: CNT_W'(16)};
            opx_r   <= {ppm_r, 56'd0};
            opd_r   <= {2'd0, ref_rf_r};
            state_r <= S_M2;
          end
        end
        S_M2: begin
          if (a_done) begin
            full_r  <= !ref_ok_r || dfbig_r || (lhs_r > {4'd0, a_acc[53:0]});
            st_r    <= ST_FULL;
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            if (st_r == ST_INVALID) begin
              out_status_r <= ST_INVALID;
              out_img_r    <= cur_img_r;
            end else begin
              out_status_r <= full_r ? ST_FULL : ST_SMOOTH;
              out_img_r    <= img;
              cur_img_r    <= img;
              if (full_r) begin
                ref_rf_r <= rf_r;
                ref_f_r  <= fq_r;
                ref_ok_r <= 1'b1;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready           = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready          = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_register_image = out_img_r;

endmodule

### hw/rtl/ocd_arith.sv
// Shared bit-serial multiply / restoring divide unit, one bit per cycle.
// Depends on ocd_pkg.
module ocd_arith (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ocd_pkg::ocd_req_t         req,
  input  logic [ocd_pkg::ACC_W-1:0] opx,
  input  logic [ocd_pkg::DEN_W-1:0] opd,
  output logic                      done,
  output logic [ocd_pkg::ACC_W-1:0] acc,
  output logic [ocd_pkg::ACC_W-1:0] quo
);
  import ocd_pkg::*;

  logic [ACC_W-1:0] x_r, y_r, q_r;
  logic [DEN_W-1:0] d_r;
  logic [CNT_W-1:0] cnt_r;
  ocd_op_t          op_r;
  logic             done_r;
  logic [ACC_W-1:0] t, d_ext, diff, sum;
  logic             ge;

  always_comb begin
    t     = {y_r[ACC_W-2:0], (op_r == OCD_DIV) ? x_r[ACC_W-1] : 1'b0};
    d_ext = {{(ACC_W-DEN_W){1'b0}}, d_r};
    diff  = t - d_ext;
    sum   = t + d_ext;
    ge    = (t >= d_ext);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        x_r   <= opx;
        d_r   <= opd;
        y_r   <= '0;
        q_r   <= '0;
        op_r  <= req.op;
        cnt_r <= req.nbits;
      end else if (cnt_r != '0) begin
        x_r   <= {x_r[ACC_W-2:0], 1'b0};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) done_r <= 1'b1;
        if (op_r == OCD_DIV) begin
          y_r <= ge ? diff : t;
          q_r <= {q_r[ACC_W-2:0], ge};
        end else begin
          y_r <= x_r[ACC_W-1] ? sum : t;
        end
      end
    end
  end

  assign done = done_r;
  assign acc  = y_r;
  assign quo  = q_r;

endmodule

### tb/tb_oscillator_divider_rfreq_calc_unit.sv
// Testbench for oscillator_divider_rfreq_calc_unit: random and directed frequency targets
// checked against a behavioral divider/RFREQ predictor. Depends on ocd_pkg and the RTL.
module tb_oscillator_divider_rfreq_calc_unit;
  import ocd_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [34:0] in_target_freq;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [47:0] out_register_image;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] image;
  } tune_result_t;

  logic [31:0] xtal;
  logic [15:0] ppm;
  logic [12:0] dco_min;
  logic [12:0] dco_max;
  logic [47:0] cur_image;
  logic [37:0] ref_rf;
  logic [34:0] ref_fr;
  logic        ref_ok;

  logic [34:0]  pending_targets[$];
  tune_result_t expected_results[$];
  int unsigned  errors;
  int unsigned  cycle_count;
  bit           quiet;
  bit           hold_sink;
  bit           in_accepted;
  int unsigned  src_gap;
  int unsigned  sink_gap;
  int unsigned  hold_cnt;

  oscillator_divider_rfreq_calc_unit u_dut (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic tune_result_t predict_tuning(input logic [34:0] f);
    tune_result_t res;
    logic [63:0] n0;
    logic [63:0] n1;
    logic [63:0] dco;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] frac;
    logic [37:0] rf;
    logic [127:0] fr;
    logic [127:0] d_rf;
    logic [63:0] d_f;
    int unsigned best_n;
    int unsigned best_hs;
    int unsigned best_n1;
    int unsigned hs;
    int unsigned prod;
    bit found;
    bit full;
    int hs_tab[6];
    hs_tab = '{11, 9, 7, 6, 5, 4};
    res.status = ST_INVALID;
    res.image = cur_image;
    if (f == 0 || xtal == 0) return res;
    n0 = ({51'd0, dco_min} << 24) / f;
    found = 0;
    best_n = 0;
    best_hs = 0;
    best_n1 = 0;
    for (int i = 0; i < 6; i++) begin
      hs = hs_tab[i];
      n1 = n0 / hs + 1;
      if (n1 > 128) continue;
      if (n1 != 1 && n1[0]) n1 = n1 + 1;
      prod = hs * 32'(n1);
      if (!found || prod < best_n) begin
        found = 1;
        best_n = prod;
        best_hs = hs;
        best_n1 = 32'(n1);
      end
    end
    dco = f * best_n;
    if (!found || dco > ({51'd0, dco_max} << 24)) return res;
    q = dco / xtal;
    r = dco % xtal;
    frac = 0;
    for (int i = 0; i < 28; i++) begin
      r = r << 1;
      frac = frac << 1;
      if (r >= xtal) begin
        r = r - xtal;
        frac[0] = 1'b1;
      end
    end
    rf = {q[9:0], frac[27:0]};
    cur_image = {3'(best_hs - 4), 7'(best_n1 - 1), rf};
    fr = 128'(xtal) * rf[37:28] + ((128'(xtal) * rf[27:0]) >> 28);
    fr = fr / (best_hs * best_n1);
    if (fr > 128'h7_FFFF_FFFF) fr = 128'h7_FFFF_FFFF;
    d_rf = (rf >= ref_rf) ? rf - ref_rf : ref_rf - rf;
    d_f = (fr[34:0] >= ref_fr) ? fr[34:0] - ref_fr : ref_fr - fr[34:0];
    if (!ref_ok) full = 1;
    else if (ref_rf == 0) full = (d_rf != 0) || (d_f > HALF_MHZ);
    else full = (d_rf * PPM_SCALE > 128'(ppm) * ref_rf) || (d_f > HALF_MHZ);
    if (full) begin
      ref_rf = rf;
      ref_fr = fr[34:0];
      ref_ok = 1;
    end
    res.status = full ? ST_FULL : ST_SMOOTH;
    res.image = cur_image;
    return res;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_accepted) begin
        void'(pending_targets.pop_front());
        if (!quiet && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 7);
      end
      if (src_gap > 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (pending_targets.size() > 0) begin
        in_valid <= 1'b1;
        in_target_freq <= pending_targets[0];
      end else begin
        in_valid <= 1'b0;
      end
      if (hold_sink) begin
        out_ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 4) == 0) sink_gap = $urandom_range(1, 7);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 4000000) begin
      $display("oscillator_divider_rfreq_calc_unit regression: fail");
      $finish;
    end
    in_accepted = rst_n && in_valid && in_ready;
    if (in_accepted) expected_results.push_back(predict_tuning(in_target_freq));
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t unexpected item: status %0d image %h", $time, out_status,
                 out_register_image);
      end else begin
        tune_result_t exp_res;
        exp_res = expected_results.pop_front();
        if (exp_res.status !== out_status) begin
          errors++;
          $display("%0t status expected %0d actual %0d", $time, exp_res.status, out_status);
        end
        if (exp_res.image !== out_register_image) begin
          errors++;
          $display("%0t image expected %h actual %h", $time, exp_res.image,
                   out_register_image);
        end
      end
    end
  end

  // long receiver hold-off
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
      if (hold_cnt == 0) hold_sink = 0;
    end
  end

  task automatic wait_drained();
    while (pending_targets.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_XTAL:    xtal = val;
      CFG_PPM:     ppm = val[15:0];
      CFG_DCO_MIN: dco_min = val[12:0];
      default:     dco_max = val[12:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // frequency near the band a DCO setting can reach, with random fraction; one in ten is fully random
  function automatic logic [34:0] near_target();
    logic [34:0] t;
    t = {11'($urandom_range(1, 1500)), 24'd0} + 35'($urandom_range(0, 24'hFF_FFFF));
    if ($urandom_range(0, 9) == 0) t = {32'($urandom), 3'($urandom_range(0, 7))};
    return t;
  endfunction

  task automatic run_burst(input int n);
    logic [34:0] base;
    base = near_target();
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: pending_targets.push_back(near_target());
        1: pending_targets.push_back(base);
        default: pending_targets.push_back(base + 35'($urandom_range(0, 20000)) - 35'd10000);
      endcase
      if ($urandom_range(0, 5) == 0) base = near_target();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_target_freq = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_XTAL;
    cfg_data = '0;
    errors = 0;
    cycle_count = 0;
    quiet = 0;
    hold_sink = 0;
    in_accepted = 0;
    hold_cnt = 0;
    src_gap = 0;
    sink_gap = 0;
    xtal = XTAL_RST;
    ppm = PPM_RST;
    dco_min = DCO_MIN_RST;
    dco_max = DCO_MAX_RST;
    cur_image = '0;
    ref_rf = '0;
    ref_fr = '0;
    ref_ok = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, invalid, smooth and full paths
    pending_targets.push_back(35'd0);
    pending_targets.push_back(35'h7_FFFF_FFFF);
    pending_targets.push_back(35'd1);
    pending_targets.push_back({11'd100, 24'd0});
    pending_targets.push_back({11'd100, 24'd0});
    pending_targets.push_back({11'd100, 24'd100});
    pending_targets.push_back({11'd101, 24'd0});
    pending_targets.push_back({11'd10, 24'd0});
    pending_targets.push_back({11'd1, 24'd0});
    pending_targets.push_back({11'd1400, 24'd0});
    pending_targets.push_back({11'd1000, 24'h80_0000});
    pending_targets.push_back({11'd3, 24'd0});
    pending_targets.push_back({11'd0, 24'h55_5555});
    pending_targets.push_back({11'h555, 24'hAA_AAAA});
    pending_targets.push_back({11'h2AA, 24'h55_5555});
    wait_drained();

    write_reg(CFG_XTAL, 32'd0);
    pending_targets.push_back({11'd100, 24'd0});
    wait_drained();
    write_reg(CFG_XTAL, 32'hFFFF_FFFF);
    write_reg(CFG_PPM, 16'd0);
    write_reg(CFG_DCO_MIN, 13'd1);
    write_reg(CFG_DCO_MAX, 13'h1FFF);
    run_burst(60);
    wait_drained();

    // receiver holds off long while the sender keeps offering
    hold_sink = 1;
    hold_cnt = 3000;
    run_burst(40);
    wait_drained();

    write_reg(CFG_XTAL, 32'd1);
    write_reg(CFG_PPM, 16'hFFFF);
    write_reg(CFG_DCO_MIN, 13'h1FFF);
    write_reg(CFG_DCO_MAX, 13'd1);
    run_burst(60);
    wait_drained();

    write_reg(CFG_XTAL, XTAL_RST);
    write_reg(CFG_PPM, PPM_RST);
    write_reg(CFG_DCO_MIN, DCO_MIN_RST);
    write_reg(CFG_DCO_MAX, DCO_MAX_RST);
    run_burst(300);
    wait_drained();

    write_reg(CFG_XTAL, $urandom);
    write_reg(CFG_PPM, $urandom_range(0, 65535));
    write_reg(CFG_DCO_MIN, $urandom_range(1000, 5000));
    write_reg(CFG_DCO_MAX, $urandom_range(5000, 8191));
    run_burst(200);
    wait_drained();

    write_reg(CFG_XTAL, XTAL_RST + $urandom_range(0, 1000000));
    write_reg(CFG_DCO_MIN, DCO_MIN_RST);
    write_reg(CFG_DCO_MAX, DCO_MAX_RST);
    quiet = 1;
    run_burst(150);
    wait_drained();

    if (errors == 0) begin
      $display("oscillator_divider_rfreq_calc_unit regression: pass");
    end else begin
      $display("oscillator_divider_rfreq_calc_unit regression: fail");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/ocd_pkg.sv
hw/rtl/ocd_arith.sv
hw/rtl/oscillator_divider_rfreq_calc_unit.sv
tb/tb_oscillator_divider_rfreq_calc_unit.sv
